// File: hw/rtl/pab_pkg.sv
// Shared types, constants and helpers for the pixel alpha blend block.
package pab_pkg;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int BPP_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CHAN_W-1:0] FULL_SCALE       = 8'd255;
  localparam logic [BPP_W-1:0]  ALPHA_SOURCE_BPP = 6'd32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONSTANT_ALPHA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_FORMAT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_OP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_FLAGS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BPP     = 3'd4;

  localparam logic [7:0] BLEND_OP_SRC_OVER = 8'd0;

  // decoded configuration seen by the datapath
  typedef struct packed {
    logic [CHAN_W-1:0] const_alpha;
    logic              per_pixel;
    logic              bad;
  } cfg_t;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]   chan_vec_t;
  typedef logic [NUM_CHAN-1:0][2*CHAN_W-1:0] prod_vec_t;

  // exact floor(p / 255) for any product of two bytes (p up to 255 * 255)
  function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] t;
    t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return t[15:8];
  endfunction

endpackage

// File: hw/rtl/pixel_alpha_blend_24bpp_top.sv
// Top level of the source-over alpha blend pipeline for 24 bpp destinations.
//
// channel | dir | handshake             | payload
// --------+-----+-----------------------+----------------------------------------
// in_     | in  | in_tvalid/in_tready   | in_tdata[55:0]: src0..2, src_alpha, dst0..2
// out_    | out | out_tvalid/out_tready | out_tdata[23:0]: chan0..2; out_tuser: rejected
// cfg_    | in  | cfg_we                | cfg_index[2:0], cfg_wdata[7:0]
//
// Four register stages; one pixel per cycle sustained while out_tready is high.
// Stage depth is set by the 8x8 multipliers and the divide-by-255 adders.
// Each stage holds its own valid bit; a stage loads when it is empty or its
// successor moves, so bubbles collapse. The input stalls only when all four
// stages hold a transaction and out_tready is low. Synchronous active-low reset
// clears valids and restores register defaults; no clearing pass is needed.
module pixel_alpha_blend_24bpp_top (
  input  logic        clk,
  input  logic        rst_n,
  // fields low to high: src_chan0, src_chan1, src_chan2, src_alpha,
  // dst_chan0, dst_chan1, dst_chan2
  input  logic [55:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fields low to high: out_chan0, out_chan1, out_chan2
  output logic [23:0] out_tdata,
  // fields low to high: rejected
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic                            cfg_we,
  input  logic [pab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pab_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pab_pkg::cfg_t cfg;

  pab_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // unpack input transaction
  pab_pkg::chan_vec_t in_src, in_dst;
  logic [7:0]         in_alpha;

  always_comb begin
    for (int c = 0; c < pab_pkg::NUM_CHAN; c++) begin
      in_src[c] = in_tdata[8*c +: 8];
      in_dst[c] = in_tdata[32 + 8*c +: 8];
    end
    in_alpha = in_tdata[31:24];
  end

  // stage handshake chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: source and alpha products
  pab_pkg::prod_vec_t ps1_r;
  logic [15:0]        pa1_r;
  pab_pkg::chan_vec_t dst1_r;
  logic               bad1_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      for (int c = 0; c < pab_pkg::NUM_CHAN; c++) begin
        ps1_r[c] <= {8'd0, in_src[c]} * {8'd0, cfg.const_alpha};
      end
      pa1_r  <= {8'd0, in_alpha} * {8'd0, cfg.const_alpha};
      dst1_r <= in_dst;
      bad1_r <= cfg.bad;
    end
  end

  // stage 2: divide by 255, form inverse alpha
  pab_pkg::chan_vec_t s2_r, dst2_r;
  logic [7:0]         inv2_r;
  logic               bad2_r;

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int c = 0; c < pab_pkg::NUM_CHAN; c++) begin
        s2_r[c] <= pab_pkg::div255(ps1_r[c]);
      end
      inv2_r <= pab_pkg::FULL_SCALE -
                (cfg.per_pixel ? pab_pkg::div255(pa1_r) : cfg.const_alpha);
      dst2_r <= dst1_r;
      bad2_r <= bad1_r;
    end
  end

  // stage 3: destination weight products
  pab_pkg::prod_vec_t pd3_r;
  pab_pkg::chan_vec_t s3_r, dst3_r;
  logic               bad3_r;

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int c = 0; c < pab_pkg::NUM_CHAN; c++) begin
        pd3_r[c] <= {8'd0, dst2_r[c]} * {8'd0, inv2_r};
      end
      s3_r   <= s2_r;
      dst3_r <= dst2_r;
      bad3_r <= bad2_r;
    end
  end

  // stage 4: divide, add, saturate, reject mux -> output register
  pab_pkg::chan_vec_t out4_nxt, out4_r;
  logic               bad4_r;

  always_comb begin
    logic [8:0] sum;
    for (int c = 0; c < pab_pkg::NUM_CHAN; c++) begin
      sum = {1'b0, pab_pkg::div255(pd3_r[c])} + {1'b0, s3_r[c]};
      if (bad3_r) begin
        out4_nxt[c] = dst3_r[c];
      end else if (sum[8]) begin
        out4_nxt[c] = pab_pkg::FULL_SCALE;
      end else begin
        out4_nxt[c] = sum[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      out4_r <= out4_nxt;
      bad4_r <= bad3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = out4_r;
  assign out_tuser  = bad4_r;

  // a middle stage that cannot advance keeps its transaction
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy4) |=> v3_r)
    else $error("stage 3 transaction dropped while stalled");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // the user must keep config static while pixels are in flight (the block does not enforce it), so a reject matches it
  a_reject_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == cfg.bad))
    else $error("reject flag disagrees with configuration");

  // input is refused only when every stage is full and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && !out_tready))
    else $error("input stalled with a free pipeline slot");

endmodule

// File: hw/rtl/pab_cfg_regs.sv
// Configuration registers and validity decode for the alpha blend block.
module pab_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pab_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pab_pkg::cfg_t                   cfg
);

  logic [7:0]                  const_alpha_r;
  logic [7:0]                  alpha_format_r;
  logic [7:0]                  blend_op_r;
  logic [7:0]                  blend_flags_r;
  logic [pab_pkg::BPP_W-1:0]   source_bpp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_alpha_r  <= pab_pkg::FULL_SCALE;
      alpha_format_r <= 8'd0;
      blend_op_r     <= pab_pkg::BLEND_OP_SRC_OVER;
      blend_flags_r  <= 8'd0;
      source_bpp_r   <= pab_pkg::ALPHA_SOURCE_BPP;
    end else if (cfg_we) begin
      case (cfg_index)
        pab_pkg::REG_CONSTANT_ALPHA: const_alpha_r  <= cfg_wdata;
        pab_pkg::REG_ALPHA_FORMAT:   alpha_format_r <= cfg_wdata;
        pab_pkg::REG_BLEND_OP:       blend_op_r     <= cfg_wdata;
        pab_pkg::REG_BLEND_FLAGS:    blend_flags_r  <= cfg_wdata;
        pab_pkg::REG_SOURCE_BPP:     source_bpp_r   <= cfg_wdata[pab_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.const_alpha = const_alpha_r;
    cfg.per_pixel   = alpha_format_r[0];
    cfg.bad         = (blend_op_r != pab_pkg::BLEND_OP_SRC_OVER) ||
                      (blend_flags_r != 8'd0) ||
                      (alpha_format_r[7:1] != 7'd0) ||
                      (alpha_format_r[0] && (source_bpp_r != pab_pkg::ALPHA_SOURCE_BPP));
  end

endmodule

// File: tb/pixel_alpha_blend_24bpp_top_tb.sv
// Self-checking bench for the source-over alpha blend pipeline: predicted pixels vs. DUT stream.
module pixel_alpha_blend_24bpp_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Widths taken from the shared package
  localparam int CHAN_W     = pab_pkg::CHAN_W;
  localparam int NUM_CHAN   = pab_pkg::NUM_CHAN;
  localparam int BPP_W      = pab_pkg::BPP_W;
  localparam int CFG_IDX_W  = pab_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pab_pkg::CFG_DATA_W;

  // Bench knobs
  localparam int IDLE_PCT      = 16;      // chance per cycle that a side idles
  localparam int HOLD_CYCLES   = 60;      // long receiver hold-off to back up the pipe
  localparam int RANDOM_ITEMS  = 450;     // random pixels after the directed part
  localparam int PIPE_LATENCY  = 4;       // register stages in the DUT
  localparam int DRAIN_CYCLES  = 8 * PIPE_LATENCY;
  localparam int LIMIT_CYCLES  = 100000;  // hard stop, far above a slow correct run
  localparam int REPORT_MAX    = 10;      // mismatches printed in full
  localparam int NUM_REG_SLOTS = 1 << CFG_IDX_W;

  // Input pixel; first member lands in the top bits, so src0 sits at bit 0
  typedef struct packed {
    logic [CHAN_W-1:0] dst2;
    logic [CHAN_W-1:0] dst1;
    logic [CHAN_W-1:0] dst0;
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] src2;
    logic [CHAN_W-1:0] src1;
    logic [CHAN_W-1:0] src0;
  } pixel_in_t;

  // Blended pixel as {out_tuser, out_tdata}
  typedef struct packed {
    logic              rejected;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan0;
  } blend_out_t;

  // Bench copy of the register file
  typedef struct {
    logic [CFG_DATA_W-1:0] const_alpha;
    logic [CFG_DATA_W-1:0] alpha_fmt;
    logic [CFG_DATA_W-1:0] op;
    logic [CFG_DATA_W-1:0] flags;
    logic [BPP_W-1:0]      src_bpp;
  } blend_regs_t;

  logic                  clk;
  logic                  rst_n;
  logic [55:0]           in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [23:0]           out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  blend_regs_t regs;
  pixel_in_t   pixel_q[$];        // pixels waiting to be offered
  blend_out_t  blend_expect_q[$]; // predicted pixels, oldest first
  pixel_in_t   pixel_cur;         // pixel currently on in_tdata
  bit          in_taken;          // set at the edge that accepted pixel_cur
  bit          idle_en;           // random idling on both sides
  bit          hold_go;           // request for the long receiver hold-off
  logic        hold_off;
  int          err_count;
  int          cycle_count;

  pixel_alpha_blend_24bpp_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor(a * b / 255) on bytes
  function automatic int unsigned scale_by_alpha(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (int'(a) * int'(b)) / int'(pab_pkg::FULL_SCALE);
  endfunction

  // Predicted output for one pixel under the current bench registers
  function automatic blend_out_t blend_pixel(input pixel_in_t p);
    blend_out_t  r;
    logic        per_pixel;
    logic        bad;
    int unsigned eff_alpha;
    logic [CHAN_W-1:0] src[NUM_CHAN];
    logic [CHAN_W-1:0] dst[NUM_CHAN];
    logic [CHAN_W-1:0] res[NUM_CHAN];
    int unsigned sum;
    src = '{p.src0, p.src1, p.src2};
    dst = '{p.dst0, p.dst1, p.dst2};
    per_pixel = regs.alpha_fmt[0];
    // any unsupported op, flag or format bit, or per-pixel alpha without 32 bpp
    bad = (regs.op != pab_pkg::BLEND_OP_SRC_OVER) || (regs.flags != '0) ||
          (regs.alpha_fmt[CFG_DATA_W-1:1] != '0) ||
          (per_pixel && regs.src_bpp != pab_pkg::ALPHA_SOURCE_BPP);
    eff_alpha = per_pixel ? scale_by_alpha(p.alpha, regs.const_alpha)
                          : int'(regs.const_alpha);
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum = scale_by_alpha(src[c], regs.const_alpha) +
            (int'(dst[c]) * (int'(pab_pkg::FULL_SCALE) - eff_alpha)) /
            int'(pab_pkg::FULL_SCALE);
      if (sum > int'(pab_pkg::FULL_SCALE)) sum = int'(pab_pkg::FULL_SCALE);  // saturate
      res[c] = bad ? dst[c] : CHAN_W'(sum);
    end
    r.chan0    = res[0];
    r.chan1    = res[1];
    r.chan2    = res[2];
    r.rejected = bad;
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return pab_pkg::FULL_SCALE;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic pixel_in_t rand_pixel();
    pixel_in_t p;
    p = {rand_byte(), rand_byte(), rand_byte(), rand_byte(),
         rand_byte(), rand_byte(), rand_byte()};
    return p;
  endfunction

  // One register write, mirrored into the bench copy with the same masking
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pab_pkg::REG_CONSTANT_ALPHA: regs.const_alpha = val;
      pab_pkg::REG_ALPHA_FORMAT:   regs.alpha_fmt   = val;
      pab_pkg::REG_BLEND_OP:       regs.op          = val;
      pab_pkg::REG_BLEND_FLAGS:    regs.flags       = val;
      pab_pkg::REG_SOURCE_BPP:     regs.src_bpp     = val[BPP_W-1:0];
      default: ;          // unmapped slots are dropped
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [7:0] ca, input logic [7:0] af, input logic [7:0] op,
                          input logic [7:0] fl, input logic [7:0] bpp);
    write_reg(pab_pkg::REG_CONSTANT_ALPHA, ca);
    write_reg(pab_pkg::REG_ALPHA_FORMAT, af);
    write_reg(pab_pkg::REG_BLEND_OP, op);
    write_reg(pab_pkg::REG_BLEND_FLAGS, fl);
    write_reg(pab_pkg::REG_SOURCE_BPP, bpp);
  endtask

  task automatic push_pixel(input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] a, input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2);
    pixel_q.push_back(pixel_in_t'{d2, d1, d0, a, s2, s1, s0});
  endtask

  // Block is idle once every pixel went in and every prediction came back
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_tvalid || blend_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // Mostly legal settings with random alpha; about a quarter carry one fault
  task automatic random_setup();
    logic [7:0] ca, af, op, fl, bpp;
    case ($urandom_range(0, 3))
      0:       ca = '0;
      1:       ca = pab_pkg::FULL_SCALE;
      default: ca = 8'($urandom);
    endcase
    af  = 8'($urandom_range(0, 1));
    op  = pab_pkg::BLEND_OP_SRC_OVER;
    fl  = '0;
    // bpp is ignored without per-pixel alpha; top bits exercise the 6-bit mask
    bpp = af[0] ? {2'($urandom), pab_pkg::ALPHA_SOURCE_BPP} : 8'($urandom);
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0: op = 8'($urandom_range(1, 255));
        1: fl = 8'($urandom_range(1, 255));
        2: af[7:1] = 7'($urandom_range(1, 127));
        default: begin
          af[0] = 1'b1;
          bpp   = 8'($urandom);
          if (bpp[BPP_W-1:0] == pab_pkg::ALPHA_SOURCE_BPP) bpp[0] = ~bpp[0];
        end
      endcase
    end
    set_regs(ca, af, op, fl, bpp);
  endtask

  // Stimulus and run control
  initial begin : stimulus
    int sent;
    int phase;
    int n;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    idle_en   = 1'b1;
    hold_go   = 1'b0;
    regs = '{pab_pkg::FULL_SCALE, 8'd0, pab_pkg::BLEND_OP_SRC_OVER, 8'd0,
             pab_pkg::ALPHA_SOURCE_BPP};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: opaque constant alpha, source replaces destination
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff); // src alpha ignored
    push_pixel(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
    push_pixel(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
    wait_idle();

    // Per-pixel alpha at half constant alpha; zero src alpha saturates the sum
    set_regs(8'h80, 8'h01, pab_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'd32);
    push_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_pixel(8'h12, 8'h9c, 8'he7, 8'h80, 8'h3b, 8'hc4, 8'h70);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // Zero constant alpha with zero source depth: legal, dest kept
    set_regs(8'h00, 8'h00, pab_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'd0);
    push_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    push_pixel(8'haa, 8'h55, 8'haa, 8'h55, 8'h55, 8'haa, 8'h55);
    wait_idle();

    // Each rejection cause on its own
    set_regs(8'hc0, 8'h00, 8'h01, 8'h00, 8'd32);                      // unknown op
    push_pixel(8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77);
    wait_idle();
    set_regs(8'hc0, 8'h00, pab_pkg::BLEND_OP_SRC_OVER, 8'hff, 8'd32); // nonzero flags
    push_pixel(8'hee, 8'hdd, 8'hcc, 8'hbb, 8'haa, 8'h99, 8'h88);
    wait_idle();
    set_regs(8'hc0, 8'h80, pab_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'd32); // unknown format bit
    push_pixel(8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00);
    wait_idle();
    set_regs(8'hc0, 8'h01, pab_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'd31); // per-pixel, not 32 bpp
    push_pixel(8'h00, 8'hff, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff);
    wait_idle();

    // Unmapped slots must be dropped; oversized bpp masks back to 32
    for (int i = int'(pab_pkg::REG_SOURCE_BPP) + 1; i < NUM_REG_SLOTS; i++)
      write_reg(CFG_IDX_W'(i), 8'hff);
    set_regs(8'hff, 8'h01, pab_pkg::BLEND_OP_SRC_OVER, 8'h00, 8'he0);
    push_pixel(8'h40, 8'h80, 8'hc0, 8'h7f, 8'hc0, 8'h80, 8'h40);
    wait_idle();

    // Random phases, a fresh setting each; one long run with no idling and
    // one with the receiver held off while the sender keeps offering
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      random_setup();
      n       = (phase == 3 || phase == 5) ? 80 : $urandom_range(20, 50);
      idle_en = (phase != 3);
      if (phase == 5) hold_go = 1'b1;
      repeat (n) pixel_q.push_back(rand_pixel());
      sent  += n;
      phase++;
      wait_idle();
    end
    idle_en = 1'b1;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && blend_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Acceptance on the input side: predict right at the edge that took the pixel
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      blend_expect_q.push_back(blend_pixel(pixel_cur));
      in_taken = 1'b1;
    end
  end

  // Sender: a new pixel only after the previous transaction, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pixel_q.size() != 0 && !(idle_en && $urandom_range(0, 99) < IDLE_PCT)) begin
        pixel_cur = pixel_q.pop_front();
        in_tdata  <= pixel_cur;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off when requested
  always @(negedge clk) begin
    out_tready <= !hold_off && !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
  end

  // Long hold-off, counted here so the sender keeps going meanwhile
  initial begin : hold_off_ctl
    hold_off = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  task automatic log_mismatch(input string what, input blend_out_t want,
                              input blend_out_t got);
    if (err_count < REPORT_MAX)
      $display("%s: exp chan %02h %02h %02h rej %0b, got chan %02h %02h %02h rej %0b",
               what, want.chan0, want.chan1, want.chan2, want.rejected,
               got.chan0, got.chan1, got.chan2, got.rejected);
    err_count++;
  endtask

  // Output side: compare every transaction against the oldest prediction
  always @(posedge clk) begin : result_check
    blend_out_t got;
    blend_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      if (blend_expect_q.size() == 0) begin
        log_mismatch("unexpected pixel", '0, got);
      end else begin
        want = blend_expect_q.pop_front();
        if (got.chan0 !== want.chan0 || got.chan1 !== want.chan1 ||
            got.chan2 !== want.chan2 || got.rejected !== want.rejected)
          log_mismatch("pixel mismatch", want, got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

// File: files.f
hw/rtl/pab_pkg.sv
hw/rtl/pab_cfg_regs.sv
hw/rtl/pixel_alpha_blend_24bpp_top.sv
tb/pixel_alpha_blend_24bpp_top_tb.sv
